### rtl/msbbp_pkg.sv
// Shared types and constants for the MSB-first bit packer.
`timescale 1ns / 1ps

package msbbp_pkg;

    localparam int ValueW = 64;
    localparam int CountW = 7;
    localparam int ByteW  = 8;
    localparam int PosW   = 64;
    // Staging word: one partial byte plus one full-width field
    localparam int StageW = ByteW + ValueW;
    // Bytes one item can complete, plus one bit to hold that count
    localparam int NumW   = 4;

    typedef enum logic [1:0] {
        CMD_WRITE    = 2'd0,
        CMD_PAD      = 2'd1,
        CMD_FINALIZE = 2'd2,
        CMD_CLEAR    = 2'd3
    } t_cmd;

    typedef enum logic [1:0] {
        ST_OK                 = 2'd0,
        ST_INVALID_STATE      = 2'd1,
        ST_INVALID_ARGUMENT   = 2'd2,
        ST_RESOURCE_EXHAUSTED = 2'd3
    } t_status;

    typedef enum logic [1:0] {
        S_IDLE  = 2'd0,
        S_CHECK = 2'd1,
        S_EMIT  = 2'd2
    } t_state;

endpackage

### rtl/msb_first_bit_packer.sv
// Top level of the MSB-first bit packer: command checks, staging shifter, byte sequencer.
`timescale 1ns / 1ps

// Channel   Dir  tdata (low bit up)                          tuser        tlast
// s_axis    in   value[63:0], nbits[70:64], zero pad         command[1:0] -
// m_axis    out  out_byte[7:0], status[9:8], position[73:10],
//                is_finalized[74], zero pad                  byte_valid   last
//
// One beat is taken at a time: after the accept, the check state checks the command and loads
// the 72-bit staging word, then the emit state sends one completed byte per cycle while the
// output is free (zero to eight per item); a status-only result is loaded in the check state.
// Reset is synchronous, active low, and clears the partial byte, position and flag.
// A stalled output holds the sequencer; the input is not ready until the last
// result of the item has been loaded into the output register.

module msb_first_bit_packer (
    input  logic        i_clk,
    input  logic        i_rst_n,
    input  logic        s_axis_tvalid,
    output logic        s_axis_tready,
    input  logic [71:0] s_axis_tdata,   // value[63:0], nbits[70:64]
    input  logic [1:0]  s_axis_tuser,   // command[1:0]
    output logic        m_axis_tvalid,
    input  logic        m_axis_tready,
    output logic [79:0] m_axis_tdata,   // out_byte[7:0], status[9:8], position[73:10],
                                        // is_finalized[74]
    output logic [0:0]  m_axis_tuser,   // byte_valid[0]
    output logic        m_axis_tlast
);

    // Control state
    msbbp_pkg::t_state r_state, n_state;
    logic [msbbp_pkg::NumW-1:0] r_cnt, n_cnt;
    logic r_sealed, n_sealed;
    logic r_mvalid, n_mvalid;

    // Stream state and item registers
    logic [msbbp_pkg::ByteW-1:0]  r_partial, n_partial;
    logic [msbbp_pkg::PosW-1:0]   r_total, n_total;
    msbbp_pkg::t_cmd              r_cmd;
    logic [msbbp_pkg::ValueW-1:0] r_value;
    logic [msbbp_pkg::CountW-1:0] r_count;
    logic [msbbp_pkg::StageW-1:0] r_w, n_w;

    // Output register
    logic [msbbp_pkg::ByteW-1:0] r_obyte, n_obyte;
    logic                        r_obv, n_obv;
    msbbp_pkg::t_status          r_ostat, n_ostat;
    logic [msbbp_pkg::PosW-1:0]  r_opos, n_opos;
    logic                        r_ofin, n_ofin;
    logic                        r_olast, n_olast;

    // Check-stage datapath
    logic                         out_free;
    logic                         in_beat;
    logic [2:0]                   fill;
    logic [msbbp_pkg::CountW-1:0] eff_count;
    logic [msbbp_pkg::ValueW-1:0] eff_value;
    logic [msbbp_pkg::ValueW-1:0] val_left;
    logic [msbbp_pkg::PosW:0]     sum;
    logic [msbbp_pkg::StageW-1:0] stage;
    logic [7:0]                   fill_sum;
    logic [msbbp_pkg::NumW-1:0]   nbytes;
    msbbp_pkg::t_status           chk_status;
    logic                         do_append;

    assign out_free = !r_mvalid || m_axis_tready;
    assign in_beat  = s_axis_tvalid && s_axis_tready;
    assign fill     = r_total[2:0];

    // Resolve the bits to append: pad writes zeros up to the byte boundary
    always_comb begin
        if (r_cmd == msbbp_pkg::CMD_PAD) begin
            eff_count = msbbp_pkg::CountW'(4'd8 - {1'b0, fill});
            eff_value = '0;
        end else begin
            eff_count = r_count;
            eff_value = r_value;
        end
        val_left = eff_value << (msbbp_pkg::CountW'(msbbp_pkg::ValueW) - eff_count);
        stage    = {r_partial, {msbbp_pkg::ValueW{1'b0}}}
                 | ({val_left, {msbbp_pkg::ByteW{1'b0}}} >> fill);
        sum      = {1'b0, r_total} + (msbbp_pkg::PosW+1)'(eff_count);
        fill_sum = {5'd0, fill} + {1'b0, eff_count};
        nbytes   = fill_sum[6:3];
    end

    // Check the command before any state changes
    always_comb begin
        chk_status = msbbp_pkg::ST_OK;
        do_append  = 1'b0;
        if (r_cmd == msbbp_pkg::CMD_CLEAR) begin
            chk_status = msbbp_pkg::ST_OK;
        end else if (r_sealed) begin
            chk_status = msbbp_pkg::ST_INVALID_STATE;
        end else if (r_cmd == msbbp_pkg::CMD_FINALIZE) begin
            if (fill != 3'd0) chk_status = msbbp_pkg::ST_INVALID_STATE;
        end else if (r_cmd == msbbp_pkg::CMD_PAD && fill == 3'd0) begin
            chk_status = msbbp_pkg::ST_OK;
        end else if (r_cmd == msbbp_pkg::CMD_WRITE &&
                     (r_count > msbbp_pkg::CountW'(msbbp_pkg::ValueW) ||
                      (r_value >> r_count) != '0)) begin
            chk_status = msbbp_pkg::ST_INVALID_ARGUMENT;
        end else if (sum[msbbp_pkg::PosW]) begin
            chk_status = msbbp_pkg::ST_RESOURCE_EXHAUSTED;
        end else begin
            do_append = 1'b1;
        end
    end

    // Next state
    always_comb begin
        n_state = r_state;
        unique case (r_state)
            msbbp_pkg::S_IDLE: begin
                if (in_beat) n_state = msbbp_pkg::S_CHECK;
            end
            msbbp_pkg::S_CHECK: begin
                if (out_free) begin
                    if (do_append && nbytes != '0) n_state = msbbp_pkg::S_EMIT;
                    else                            n_state = msbbp_pkg::S_IDLE;
                end
            end
            msbbp_pkg::S_EMIT: begin
                if (out_free && r_cnt == msbbp_pkg::NumW'(1)) n_state = msbbp_pkg::S_IDLE;
            end
            default: n_state = msbbp_pkg::S_IDLE;
        endcase
    end

    // Datapath and outputs of the sequencer
    always_comb begin
        n_cnt     = r_cnt;
        n_sealed  = r_sealed;
        n_partial = r_partial;
        n_total   = r_total;
        n_w       = r_w;
        n_mvalid  = r_mvalid && !m_axis_tready;
        n_obyte   = r_obyte;
        n_obv     = r_obv;
        n_ostat   = r_ostat;
        n_opos    = r_opos;
        n_ofin    = r_ofin;
        n_olast   = r_olast;
        unique case (r_state)
            msbbp_pkg::S_IDLE: begin
            end
            msbbp_pkg::S_CHECK: begin
                if (out_free) begin
                    // Commit the state change of the item
                    if (r_cmd == msbbp_pkg::CMD_CLEAR) begin
                        n_sealed  = 1'b0;
                        n_partial = '0;
                        n_total   = '0;
                    end else if (do_append) begin
                        n_total = sum[msbbp_pkg::PosW-1:0];
                        if (nbytes == '0) n_partial = stage[msbbp_pkg::StageW-1 -: 8];
                    end else if (r_cmd == msbbp_pkg::CMD_FINALIZE &&
                                 chk_status == msbbp_pkg::ST_OK) begin
                        n_sealed = 1'b1;
                    end
                    n_w   = stage;
                    n_cnt = nbytes;
                    // Status-only result unless bytes follow
                    if (!(do_append && nbytes != '0)) begin
                        n_mvalid = 1'b1;
                        n_obyte  = '0;
                        n_obv    = 1'b0;
                        n_ostat  = chk_status;
                        n_opos   = n_total;
                        n_ofin   = n_sealed;
                        n_olast  = 1'b1;
                    end
                end
            end
            msbbp_pkg::S_EMIT: begin
                // Shift one completed byte out per cycle while the output is free
                if (out_free) begin
                    n_mvalid = 1'b1;
                    n_obyte  = r_w[msbbp_pkg::StageW-1 -: 8];
                    n_obv    = 1'b1;
                    n_ostat  = msbbp_pkg::ST_OK;
                    n_opos   = r_total;
                    n_ofin   = r_sealed;
                    n_olast  = (r_cnt == msbbp_pkg::NumW'(1));
                    n_w      = r_w << msbbp_pkg::ByteW;
                    n_cnt    = r_cnt - msbbp_pkg::NumW'(1);
                    if (r_cnt == msbbp_pkg::NumW'(1))
                        n_partial = r_w[msbbp_pkg::StageW-9 -: 8];
                end
            end
            default: begin
            end
        endcase
    end

    // Control registers
    always_ff @(posedge i_clk) begin
        if (!i_rst_n) begin
            r_state   <= msbbp_pkg::S_IDLE;
            r_cnt     <= '0;
            r_sealed  <= 1'b0;
            r_mvalid  <= 1'b0;
            r_partial <= '0;
            r_total   <= '0;
        end else begin
            r_state   <= n_state;
            r_cnt     <= n_cnt;
            r_sealed  <= n_sealed;
            r_mvalid  <= n_mvalid;
            r_partial <= n_partial;
            r_total   <= n_total;
        end
    end

    // Payload registers
    always_ff @(posedge i_clk) begin
        if (in_beat) begin
            r_cmd   <= msbbp_pkg::t_cmd'(s_axis_tuser);
            r_value <= s_axis_tdata[63:0];
            r_count <= s_axis_tdata[70:64];
        end
        r_w     <= n_w;
        r_obyte <= n_obyte;
        r_obv   <= n_obv;
        r_ostat <= n_ostat;
        r_opos  <= n_opos;
        r_ofin  <= n_ofin;
        r_olast <= n_olast;
    end

    assign s_axis_tready = (r_state == msbbp_pkg::S_IDLE);
    assign m_axis_tvalid = r_mvalid;
    assign m_axis_tdata  = {5'd0, r_ofin, r_opos, r_ostat, r_obyte};
    assign m_axis_tuser  = r_obv;
    assign m_axis_tlast  = r_olast;

endmodule

### rtl/msbbp_checker.sv
// Port-level assertions for the MSB-first bit packer, bound to the top level.
`timescale 1ns / 1ps

module msbbp_checker (
    input logic        i_clk,
    input logic        i_rst_n,
    input logic        s_axis_tvalid,
    input logic        s_axis_tready,
    input logic        m_axis_tvalid,
    input logic        m_axis_tready,
    input logic [79:0] m_axis_tdata,
    input logic [0:0]  m_axis_tuser,
    input logic        m_axis_tlast
);

    // Hold a stalled result beat
    a_out_hold: assert property (@(posedge i_clk) disable iff (!i_rst_n)
        m_axis_tvalid && !m_axis_tready |=> m_axis_tvalid && $stable(m_axis_tdata))
        else $error("stalled result beat changed");

    // Drop ready after an accepted beat: one item at a time
    a_one_item: assert property (@(posedge i_clk) disable iff (!i_rst_n)
        s_axis_tvalid && s_axis_tready |=> !s_axis_tready)
        else $error("input accepted while an item is in progress");

    // An error result is a single status-only beat
    a_err_alone: assert property (@(posedge i_clk) disable iff (!i_rst_n)
        m_axis_tvalid && m_axis_tdata[9:8] != msbbp_pkg::ST_OK
        |-> m_axis_tlast && !m_axis_tuser[0])
        else $error("error result not a lone status beat");

    // A status-only beat carries a zero byte
    a_zero_byte: assert property (@(posedge i_clk) disable iff (!i_rst_n)
        m_axis_tvalid && !m_axis_tuser[0] |-> m_axis_tdata[7:0] == 8'd0 && m_axis_tlast)
        else $error("status-only beat with nonzero byte");

endmodule

bind msb_first_bit_packer msbbp_checker u_msbbp_checker (
    .i_clk         (i_clk),
    .i_rst_n       (i_rst_n),
    .s_axis_tvalid (s_axis_tvalid),
    .s_axis_tready (s_axis_tready),
    .m_axis_tvalid (m_axis_tvalid),
    .m_axis_tready (m_axis_tready),
    .m_axis_tdata  (m_axis_tdata),
    .m_axis_tuser  (m_axis_tuser),
    .m_axis_tlast  (m_axis_tlast)
);
